@@ design/ohl_pkg.sv @@
// ohl_pkg: shared types and codes for the ordered handle list
// no dependencies; used by ohl_cell and ordered_handle_list
`timescale 1ns / 1ps

package ohl_pkg;

	localparam int HANDLE_W = 16;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		REQ_APPEND    = 2'd0,
		REQ_REMOVE    = 2'd1,
		REQ_POP_FIRST = 2'd2,
		REQ_POP_LAST  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell, already qualified by the transfer
	typedef struct packed {
		logic append;
		logic remove;
		logic pop_first;
		logic pop_last;
	} cmd_t;

endpackage

@@ design/ohl_cell.sv @@
// ohl_cell: one slot of the handle chain with its valid flag
// depends on ohl_pkg (cmd_t)
`timescale 1ns / 1ps

module ohl_cell #(
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ohl_pkg::cmd_t          cmd,
	input  logic [HANDLE_BITS-1:0] key,
	input  logic                   prev_valid,
	input  logic                   next_valid,
	input  logic [HANDLE_BITS-1:0] next_value,
	input  logic                   hit_in,
	output logic                   hit_out,
	input  logic [HANDLE_BITS-1:0] tail_in,
	output logic [HANDLE_BITS-1:0] tail_out,
	output logic                   valid,
	output logic [HANDLE_BITS-1:0] value
);

	logic                   valid_q;
	logic [HANDLE_BITS-1:0] slot_q;
	logic                   match;
	logic                   shift;
	logic                   write;
	logic                   drop;
	logic                   is_tail;

	assign match    = valid_q && (slot_q == key);
	assign hit_out  = hit_in | match;
	assign shift    = cmd.pop_first | (cmd.remove & hit_out);
	assign write    = cmd.append & prev_valid & ~valid_q;
	assign is_tail  = valid_q & ~next_valid;
	assign drop     = cmd.pop_last & is_tail;
	assign tail_out = tail_in | (is_tail ? slot_q : '0);
	assign valid    = valid_q;
	assign value    = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (write) begin
			valid_q <= 1'b1;
		end else if (drop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			slot_q <= next_value;
		end else if (write) begin
			slot_q <= key;
		end
	end

endmodule

@@ design/ordered_handle_list.sv @@
// ordered_handle_list: ordered list of handles kept in a chain of ohl_cell slots
// depends on ohl_pkg and ohl_cell
//
//  channel  | handshake          | fields
//  ---------+--------------------+--------------------------------
//  request  | start, busy        | req_type, handle
//  result   | done (one cycle)   | handle_out, status, count
//
// one request per clock while busy is low; its result is on the result ports in the next cycle
// every cell compares and shifts in the same cycle, so the chain sets the rate
// busy is high only from reset until the first clock after reset release
// reset empties the list; slot contents are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps

module ordered_handle_list #(
	parameter int CAPACITY    = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   req_type,
	input  logic [ohl_pkg::HANDLE_W-1:0] handle,
	output logic                         done,
	output logic [ohl_pkg::HANDLE_W-1:0] handle_out,
	output logic [1:0]                   status,
	output logic [ohl_pkg::COUNT_W-1:0]  count
);

	localparam int FILL_W = $clog2(CAPACITY + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [ohl_pkg::HANDLE_W-1:0] handle_out_q;
	ohl_pkg::status_t       status_q;
	logic [ohl_pkg::COUNT_W-1:0]  count_q;
	logic [FILL_W-1:0]      fill_q;

	logic                   accept;
	ohl_pkg::req_t          req;
	ohl_pkg::cmd_t          cmd;
	logic [HANDLE_BITS-1:0] key;
	logic                   full;
	logic                   empty;
	logic                   found;
	logic [HANDLE_BITS-1:0] taken;
	ohl_pkg::status_t       status_d;
	logic [FILL_W-1:0]      fill_d;

	logic [CAPACITY-1:0]    valid_vec;
	logic [HANDLE_BITS-1:0] value_vec [CAPACITY];
	logic [CAPACITY:0]      hit_chain;
	logic [HANDLE_BITS-1:0] tail_chain [CAPACITY+1];

	assign accept = start & ~busy_q;
	assign req    = ohl_pkg::req_t'(req_type);
	assign key    = HANDLE_BITS'({{HANDLE_BITS{1'b0}}, handle});
	assign full   = valid_vec[CAPACITY-1];
	assign empty  = ~valid_vec[0];
	assign found  = hit_chain[CAPACITY];

	assign hit_chain[0]  = 1'b0;
	assign tail_chain[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                   prev_v;
		logic                   next_v;
		logic [HANDLE_BITS-1:0] next_d;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = valid_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_inner
			assign next_v = valid_vec[i+1];
			assign next_d = value_vec[i+1];
		end

		ohl_cell #(
			.HANDLE_BITS(HANDLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.key       (key),
			.prev_valid(prev_v),
			.next_valid(next_v),
			.next_value(next_d),
			.hit_in    (hit_chain[i]),
			.hit_out   (hit_chain[i+1]),
			.tail_in   (tail_chain[i]),
			.tail_out  (tail_chain[i+1]),
			.valid     (valid_vec[i]),
			.value     (value_vec[i])
		);
	end

	// request decode
	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (req)
				ohl_pkg::REQ_APPEND:    cmd.append    = 1'b1;
				ohl_pkg::REQ_REMOVE:    cmd.remove    = 1'b1;
				ohl_pkg::REQ_POP_FIRST: cmd.pop_first = 1'b1;
				ohl_pkg::REQ_POP_LAST:  cmd.pop_last  = 1'b1;
				default:                cmd = '0;
			endcase
		end
	end

	// result and new fill
	always_comb begin
		taken    = '0;
		status_d = ohl_pkg::ST_DONE;
		fill_d   = fill_q;
		unique case (req)
			ohl_pkg::REQ_APPEND: begin
				if (full) begin
					status_d = ohl_pkg::ST_FULL;
				end else begin
					fill_d = fill_q + FILL_W'(1);
				end
			end
			ohl_pkg::REQ_REMOVE: begin
				if (found) begin
					taken  = key;
					fill_d = fill_q - FILL_W'(1);
				end else begin
					status_d = ohl_pkg::ST_EMPTY;
				end
			end
			ohl_pkg::REQ_POP_FIRST: begin
				if (empty) begin
					status_d = ohl_pkg::ST_EMPTY;
				end else begin
					taken  = value_vec[0];
					fill_d = fill_q - FILL_W'(1);
				end
			end
			ohl_pkg::REQ_POP_LAST: begin
				if (empty) begin
					status_d = ohl_pkg::ST_EMPTY;
				end else begin
					taken  = tail_chain[CAPACITY];
					fill_d = fill_q - FILL_W'(1);
				end
			end
			default: begin
				status_d = ohl_pkg::ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			fill_q <= '0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (accept) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			handle_out_q <= ohl_pkg::HANDLE_W'({{ohl_pkg::HANDLE_W{1'b0}}, taken});
			status_q     <= status_d;
			count_q      <= ohl_pkg::COUNT_W'({{ohl_pkg::COUNT_W{1'b0}}, fill_d});
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign handle_out = handle_out_q;
	assign status     = status_q;
	assign count      = count_q;

	a_done_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start & ~busy))
		else $error("result without a request transfer");

	a_fill_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == fill_q)
		else $error("fill count disagrees with cell valid flags");

	a_full_means_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ohl_pkg::ST_FULL |-> fill_q == FILL_W'(CAPACITY))
		else $error("full status below capacity");

	a_fail_returns_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ohl_pkg::ST_DONE |-> handle_out == '0)
		else $error("nonzero handle on a failed request");

endmodule
